// File: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer shared types and constants
// Field widths, function codes, character codes and controller commands.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int PAGES_DEF      = 8;
   localparam int PAGE_CELLS_DEF = 2048;
   localparam int COLUMNS_DEF    = 80;
   localparam int ROWS           = 25;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CHAR_W = 8;
   localparam int ADDR_W = 14;
   localparam int FUNC_W = 3;
   localparam int PAGE_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_PUT   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PLACE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

   localparam logic [2:0] REG_WIN_LEFT   = 3'd0;
   localparam logic [2:0] REG_WIN_TOP    = 3'd1;
   localparam logic [2:0] REG_WIN_RIGHT  = 3'd2;
   localparam logic [2:0] REG_WIN_BOTTOM = 3'd3;
   localparam logic [2:0] REG_TEXT_ATTR  = 3'd4;
   localparam logic [2:0] REG_PAGE       = 3'd5;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request, settle window
      logic rd_cur;     // read cell at cursor (put char)
      logic rd_bs;      // read cell left of cursor (backspace)
      logic rd_req;     // read cell at request place
      logic wr_put;     // write char keeping attribute
      logic wr_bs;      // write blank keeping attribute
      logic wr_cell;    // write request char/attr
      logic sweep_init; // start a scroll or clear sweep
      logic sweep_step; // one sweep step
      logic finish;     // update cursor, load result
      logic out_take;   // result taken
   } tcw_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              is_tab;
      logic              is_nl;
      logic              is_bs;
      logic              bs_ok;
      logic              need_scroll;
      logic              sweep_done;
      logic              out_valid;
   } tcw_sts_type;

endpackage

// File: src/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_req_if / tcw_rsp_if: request and response channels
// Valid/ready handshake with the item payload.
// ----------------------------------------------------------------------------
interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::FUNC_W-1:0]    func;
   logic [tcw_pkg::CHAR_W-1:0]    ch;
   logic [tcw_pkg::COL_W-1:0]     col;
   logic [tcw_pkg::ROW_W-1:0]     row;
   logic [tcw_pkg::CHAR_W-1:0]    attr;
   modport source (output valid, func, ch, col, row, attr, input ready);
   modport sink   (input valid, func, ch, col, row, attr, output ready);
endinterface

interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::COL_W-1:0]     cursor_col;
   logic [tcw_pkg::ROW_W-1:0]     cursor_row;
   logic [tcw_pkg::ADDR_W-1:0]    cursor_address;
   logic [tcw_pkg::CHAR_W-1:0]    cell_char;
   logic [tcw_pkg::CHAR_W-1:0]    cell_attr;
   logic                          scrolled;
   modport source (output valid, cursor_col, cursor_row, cursor_address, cell_char,
                   cell_attr, scrolled, input ready);
   modport sink   (input valid, cursor_col, cursor_row, cursor_address, cell_char,
                   cell_attr, scrolled, output ready);
endinterface

// File: src/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: operation sequencer
// One-hot state machine that steps the datapath through one item.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   input  tcw_pkg::tcw_sts_type sts,
   output tcw_pkg::tcw_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_RDWAIT = 7'b0000100,
      ST_MODIFY = 7'b0001000,
      ST_SWEEP  = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_HOLD   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   assign take      = sts.out_valid && rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!sts.out_valid || rsp_ready);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_take = take;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.func)
               tcw_pkg::FUNC_PUT: begin
                  if (sts.is_tab || sts.is_nl) begin
                     if (sts.need_scroll) begin
                        cmd.sweep_init = 1'b1;
                        state_in = ST_SWEEP;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end else if (sts.is_bs) begin
                     if (sts.bs_ok) begin
                        cmd.rd_bs = 1'b1;
                        state_in = ST_RDWAIT;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end else begin
                     cmd.rd_cur = 1'b1;
                     state_in = ST_RDWAIT;
                  end
               end
               tcw_pkg::FUNC_CLEAR: begin
                  cmd.sweep_init = 1'b1;
                  state_in = ST_SWEEP;
               end
               tcw_pkg::FUNC_WRITE: begin
                  cmd.wr_cell = 1'b1;
                  state_in = ST_FINISH;
               end
               tcw_pkg::FUNC_READ: begin
                  cmd.rd_req = 1'b1;
                  state_in = ST_RDWAIT;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_RDWAIT: state_in = ST_MODIFY;
         ST_MODIFY: begin
            if (sts.func == tcw_pkg::FUNC_PUT) begin
               if (sts.is_bs) begin
                  cmd.wr_bs = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  cmd.wr_put = 1'b1;
                  if (sts.need_scroll) begin
                     cmd.sweep_init = 1'b1;
                     state_in = ST_SWEEP;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!sts.out_valid || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!sts.out_valid || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

`ifndef NO_ASSERTIONS
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == ST_IDLE)) else $error("load outside idle");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.wr_put, cmd.wr_bs, cmd.wr_cell}) <= 1) else $error("two writes");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!sts.out_valid || rsp_ready)) else $error("result overwritten");
`endif

endmodule

// File: src/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp: text console datapath
// Cell memory, per-page cursors, window bounds, sweep counters, result register.
// ----------------------------------------------------------------------------
module tcw_dp #(
   parameter int PAGES      = tcw_pkg::PAGES_DEF,
   parameter int PAGE_CELLS = tcw_pkg::PAGE_CELLS_DEF,
   parameter int COLUMNS    = tcw_pkg::COLUMNS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tcw_pkg::tcw_cmd_type        cmd,
   output tcw_pkg::tcw_sts_type        sts,
   input  logic [tcw_pkg::FUNC_W-1:0]  req_func,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_ch,
   input  logic [tcw_pkg::COL_W-1:0]   req_col,
   input  logic [tcw_pkg::ROW_W-1:0]   req_row,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_attr,
   input  logic [tcw_pkg::COL_W-1:0]   win_left,
   input  logic [tcw_pkg::ROW_W-1:0]   win_top,
   input  logic [tcw_pkg::COL_W-1:0]   win_right,
   input  logic [tcw_pkg::ROW_W-1:0]   win_bottom,
   input  logic [tcw_pkg::CHAR_W-1:0]  text_attr,
   input  logic [tcw_pkg::PAGE_W-1:0]  page_sel,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::ADDR_W-1:0]  rsp_cursor_address,
   output logic [tcw_pkg::CHAR_W-1:0]  rsp_cell_char,
   output logic [tcw_pkg::CHAR_W-1:0]  rsp_cell_attr,
   output logic                        rsp_scrolled,
   output logic                        rsp_valid
);

   localparam int COL_W   = tcw_pkg::COL_W;
   localparam int ROW_W   = tcw_pkg::ROW_W;
   localparam int CW      = tcw_pkg::CHAR_W;
   localparam int PG_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int MEM_D   = PAGES * PAGE_CELLS;
   localparam int MA_W    = $clog2(MEM_D);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(tcw_pkg::ROWS - 1);
   localparam logic [tcw_pkg::PAGE_W:0] PAGES_V = (tcw_pkg::PAGE_W+1)'(PAGES);

   logic [2*CW-1:0]  mem [MEM_D];
   logic [2*CW-1:0]  rdata_ff;

   logic [COL_W-1:0] pcol_ff [PAGES];
   logic [ROW_W-1:0] prow_ff [PAGES];

   // captured request and settled window
   logic [tcw_pkg::FUNC_W-1:0] func_ff;
   logic [CW-1:0]    ch_ff, attr_ff;
   logic [COL_W-1:0] rcol_ff, x_ff, wl_ff, wr_ff;
   logic [ROW_W-1:0] rrow_ff, y_ff, wt_ff, wb_ff;
   logic [PG_W-1:0]  pg_ff;
   logic             scr_ff;

   // sweep: clear or scroll; a scroll cell above the bottom row is read, then written
   logic             clr_ff, phase_ff;
   logic [COL_W-1:0] sc_ff;
   logic [ROW_W-1:0] sr_ff;

   logic [tcw_pkg::PAGE_W:0] pg_red;
   logic [PG_W-1:0]  pg_now;
   logic [COL_W-1:0] x_now, wl_s, wr_s, x_nx, tab_x;
   logic [ROW_W-1:0] y_now, wt_s, wb_s, y_lf;
   logic             ovf;

   // row*COLUMNS + page*PAGE_CELLS + col, truncated to the memory address width
   function automatic logic [MA_W-1:0] cell_addr(input logic [PG_W-1:0] p,
                                                 input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
      logic [MA_W+PG_W:0] s;
      begin
         s = (MA_W+PG_W+1)'(p) * (MA_W+PG_W+1)'(PAGE_CELLS)
           + (MA_W+PG_W+1)'(r) * (MA_W+PG_W+1)'(COLUMNS) + (MA_W+PG_W+1)'(c);
         cell_addr = MA_W'(s);
      end
   endfunction

   // page number folded into the page count by repeated compare and subtract
   always_comb begin
      pg_red = {1'b0, page_sel};
      for (int k = 0; k < (1 << tcw_pkg::PAGE_W) - 1; k++) begin
         if (pg_red >= PAGES_V) pg_red = pg_red - PAGES_V;
      end
   end

   assign pg_now = PG_W'(pg_red);
   assign x_now  = (pcol_ff[pg_now] > LAST_COL) ? LAST_COL : pcol_ff[pg_now];
   assign y_now  = (prow_ff[pg_now] > LAST_ROW) ? LAST_ROW : prow_ff[pg_now];
   assign wl_s   = (win_left > LAST_COL) ? LAST_COL : win_left;
   assign wt_s   = (win_top > LAST_ROW) ? LAST_ROW : win_top;

   always_comb begin
      wr_s = (win_right > LAST_COL) ? LAST_COL : win_right;
      if (wr_s < wl_s) wr_s = wl_s;
      wb_s = (win_bottom > LAST_ROW) ? LAST_ROW : win_bottom;
      if (wb_s < wt_s) wb_s = wt_s;
   end

   // cursor motion from the captured cursor
   assign tab_x = {x_ff[COL_W-1:3], 3'b000} + COL_W'(8);
   always_comb begin
      x_nx = x_ff + COL_W'(1);
      ovf  = 1'b0;
      if (ch_ff == tcw_pkg::CH_TAB) begin
         x_nx = tab_x;
         ovf  = tab_x > wr_ff;
      end else if (ch_ff == tcw_pkg::CH_NL) begin
         ovf  = 1'b1;
      end else if (ch_ff == tcw_pkg::CH_BS) begin
         x_nx = x_ff - COL_W'(1);
      end else begin
         ovf  = (x_ff + COL_W'(1)) > wr_ff;
      end
   end
   assign y_lf = (y_ff == wb_ff) ? y_ff : ((y_ff < LAST_ROW) ? y_ff + ROW_W'(1) : y_ff);

   assign sts.func        = func_ff;
   assign sts.is_tab      = ch_ff == tcw_pkg::CH_TAB;
   assign sts.is_nl       = ch_ff == tcw_pkg::CH_NL;
   assign sts.is_bs       = ch_ff == tcw_pkg::CH_BS;
   assign sts.bs_ok       = x_ff > wl_ff;
   assign sts.need_scroll = ovf && (y_ff == wb_ff);
   assign sts.sweep_done  = clr_ff ? (sc_ff == wr_ff && sr_ff == wb_ff)
                                   : (sr_ff == wb_ff && sc_ff == wr_ff);
   assign sts.out_valid   = rsp_valid;

   // sweep address and data
   logic [MA_W-1:0]  sw_addr, src_addr;
   logic [2*CW-1:0]  sw_data;
   logic             sw_wr, sw_rd;
   always_comb begin
      sw_rd    = 1'b0;
      sw_wr    = 1'b0;
      src_addr = cell_addr(pg_ff, sr_ff + ROW_W'(1), sc_ff);
      sw_addr  = cell_addr(pg_ff, sr_ff, sc_ff);
      sw_data  = {text_attr, tcw_pkg::CH_BLANK};
      if (cmd.sweep_step) begin
         if (clr_ff) begin
            sw_wr = 1'b1;
         end else if (sr_ff == wb_ff) begin
            sw_wr   = 1'b1;
            sw_data = {text_attr, {CW{1'b0}}};
         end else if (!phase_ff) begin
            sw_rd = 1'b1;
         end else begin
            // copy data read in phase 0
            sw_wr   = 1'b1;
            sw_data = rdata_ff;
         end
      end
   end

   // cell memory port
   logic [MA_W-1:0] wa, ra;
   logic [2*CW-1:0] wd;
   logic            we, re;
   always_comb begin
      we = 1'b0;
      re = cmd.rd_cur || cmd.rd_bs || cmd.rd_req || sw_rd;
      wa = cell_addr(pg_ff, y_ff, x_ff);
      wd = {rdata_ff[2*CW-1:CW], ch_ff};
      ra = cell_addr(pg_ff, y_ff, x_ff);
      if (cmd.rd_bs) ra = cell_addr(pg_ff, y_ff, x_ff - COL_W'(1));
      if (cmd.rd_req) ra = cell_addr(pg_ff, rrow_ff, rcol_ff);
      if (sw_rd) ra = src_addr;
      if (cmd.wr_put) we = 1'b1;
      if (cmd.wr_bs) begin
         we = 1'b1;
         wa = cell_addr(pg_ff, y_ff, x_ff - COL_W'(1));
         wd = {rdata_ff[2*CW-1:CW], tcw_pkg::CH_BLANK};
      end
      if (cmd.wr_cell) begin
         we = 1'b1;
         wa = cell_addr(pg_ff, rrow_ff, rcol_ff);
         wd = {attr_ff, ch_ff};
      end
      if (sw_wr) begin
         we = 1'b1;
         wa = sw_addr;
         wd = sw_data;
      end
   end

   // read data held until the next read command
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (re) rdata_ff <= mem[ra];
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         ch_ff   <= req_ch;
         attr_ff <= req_attr;
         rcol_ff <= (req_col > LAST_COL) ? LAST_COL : req_col;
         rrow_ff <= (req_row > LAST_ROW) ? LAST_ROW : req_row;
         x_ff    <= x_now;
         y_ff    <= y_now;
         pg_ff   <= pg_now;
         wl_ff   <= wl_s;
         wr_ff   <= wr_s;
         wt_ff   <= wt_s;
         wb_ff   <= wb_s;
      end
   end

   // sweep counters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else if (cmd.sweep_init) begin
         phase_ff <= 1'b0;
      end else if (cmd.sweep_step && !clr_ff && sr_ff != wb_ff) begin
         phase_ff <= !phase_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.sweep_init) begin
         clr_ff <= func_ff == tcw_pkg::FUNC_CLEAR;
         sc_ff  <= wl_ff;
         sr_ff  <= (func_ff == tcw_pkg::FUNC_CLEAR) ? wt_ff : wt_ff;
      end else if (cmd.sweep_step && (clr_ff || sr_ff == wb_ff || phase_ff)) begin
         if (sc_ff == wr_ff) begin
            sc_ff <= wl_ff;
            sr_ff <= sr_ff + ROW_W'(1);
         end else begin
            sc_ff <= sc_ff + COL_W'(1);
         end
      end
   end

   // scroll flag
   always_ff @(posedge clock) begin
      if (cmd.load)            scr_ff <= 1'b0;
      else if (cmd.sweep_init) scr_ff <= func_ff != tcw_pkg::FUNC_CLEAR;
   end

   // cursor update and result
   logic [COL_W-1:0] fx;
   logic [ROW_W-1:0] fy;
   logic [MA_W+PG_W:0] fa;
   always_comb begin
      fx = x_ff;
      fy = y_ff;
      case (func_ff)
         tcw_pkg::FUNC_PUT: begin
            if (ovf) begin
               fx = wl_ff;
               fy = y_lf;
            end else if (ch_ff != tcw_pkg::CH_BS || x_ff > wl_ff) begin
               fx = x_nx;
            end
         end
         tcw_pkg::FUNC_PLACE: begin
            fx = rcol_ff;
            fy = rrow_ff;
         end
         tcw_pkg::FUNC_CLEAR: begin
            fx = wl_ff;
            fy = wt_ff;
         end
         default: ;
      endcase
      fa = (MA_W+PG_W+1)'(fx) + (MA_W+PG_W+1)'(fy) * (MA_W+PG_W+1)'(COLUMNS)
         + (MA_W+PG_W+1)'(pg_ff) * (MA_W+PG_W+1)'(PAGE_CELLS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PAGES; p++) begin
            pcol_ff[p] <= '0;
            prow_ff[p] <= '0;
         end
      end else if (cmd.finish) begin
         pcol_ff[pg_ff] <= fx;
         prow_ff[pg_ff] <= fy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)              rsp_valid <= 1'b0;
      else if (cmd.finish)    rsp_valid <= 1'b1;
      else if (cmd.out_take)  rsp_valid <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_cursor_col     <= fx;
         rsp_cursor_row     <= fy;
         rsp_cursor_address <= tcw_pkg::ADDR_W'(fa);
         rsp_scrolled       <= scr_ff;
         if (func_ff == tcw_pkg::FUNC_READ) begin
            rsp_cell_char <= rdata_ff[CW-1:0];
            rsp_cell_attr <= rdata_ff[2*CW-1:CW];
         end else begin
            rsp_cell_char <= '0;
            rsp_cell_attr <= '0;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_sweep_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_step |-> (sr_ff <= wb_ff && sc_ff <= wr_ff)) else $error("sweep left window");
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_cursor_col <= LAST_COL && rsp_cursor_row <= LAST_ROW))
      else $error("cursor out of page");
   a_read_only_cell: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && func_ff != tcw_pkg::FUNC_READ) |=> (rsp_cell_char == '0))
      else $error("cell data on non-read");
`endif

endmodule

// File: src/tcw_csr.sv
// ----------------------------------------------------------------------------
// tcw_csr: window, attribute and page registers behind the APB-style port
// ----------------------------------------------------------------------------
module tcw_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [4:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output logic [tcw_pkg::COL_W-1:0]  win_left,
   output logic [tcw_pkg::ROW_W-1:0]  win_top,
   output logic [tcw_pkg::COL_W-1:0]  win_right,
   output logic [tcw_pkg::ROW_W-1:0]  win_bottom,
   output logic [tcw_pkg::CHAR_W-1:0] text_attr,
   output logic [tcw_pkg::PAGE_W-1:0] page_sel
);
   logic [2:0] idx;
   logic       wr;
   assign idx    = paddr[4:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left    <= '0;
         win_top     <= '0;
         win_right   <= 7'd79;
         win_bottom  <= 5'd24;
         text_attr   <= 8'd7;
         page_sel    <= '0;
      end else if (wr) begin
         case (idx)
            tcw_pkg::REG_WIN_LEFT:   win_left    <= pwdata[6:0];
            tcw_pkg::REG_WIN_TOP:    win_top     <= pwdata[4:0];
            tcw_pkg::REG_WIN_RIGHT:  win_right   <= pwdata[6:0];
            tcw_pkg::REG_WIN_BOTTOM: win_bottom  <= pwdata[4:0];
            tcw_pkg::REG_TEXT_ATTR:  text_attr   <= pwdata[7:0];
            tcw_pkg::REG_PAGE:       page_sel    <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         tcw_pkg::REG_WIN_LEFT:   prdata = {25'd0, win_left};
         tcw_pkg::REG_WIN_TOP:    prdata = {27'd0, win_top};
         tcw_pkg::REG_WIN_RIGHT:  prdata = {25'd0, win_right};
         tcw_pkg::REG_WIN_BOTTOM: prdata = {27'd0, win_bottom};
         tcw_pkg::REG_TEXT_ATTR:  prdata = {24'd0, text_attr};
         tcw_pkg::REG_PAGE:       prdata = {29'd0, page_sel};
         default:                 prdata = '0;
      endcase
   end
endmodule

// File: src/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit: paged text console writer
// Character/attribute cell buffer with per-page cursors, scrolling window.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | valid/ready        | func ch col row attr
//  rsp     | out | valid/ready        | cursor_col/row/address cell_char/attr scrolled
//  csr     | in  | psel/penable/pready| 6 registers at 4*i
//
//  Steps: place/write/unused, tab/newline without scroll and backspace at the left
//  edge go from decode to finish; read/char/backspace read one cell first (char and
//  backspace then write it). A scroll copies window rows up and sets the bottom row
//  to char 0; a clear blanks each window cell (up to 2000). One read, one write port.
//  Reset clears cursors and loads register defaults; cell memory is not cleared.
//  One item in flight; the next is taken once its result register is free.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
   parameter int PAGES      = tcw_pkg::PAGES_DEF,
   parameter int PAGE_CELLS = tcw_pkg::PAGE_CELLS_DEF,
   parameter int COLUMNS    = tcw_pkg::COLUMNS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tcw_req_if.sink     req,
   tcw_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   tcw_pkg::tcw_cmd_type cmd;
   tcw_pkg::tcw_sts_type sts;

   logic [tcw_pkg::COL_W-1:0]  win_left, win_right;
   logic [tcw_pkg::ROW_W-1:0]  win_top, win_bottom;
   logic [tcw_pkg::CHAR_W-1:0] text_attr;
   logic [tcw_pkg::PAGE_W-1:0] page_sel;

   tcw_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready),
      .win_left, .win_top, .win_right, .win_bottom, .text_attr, .page_sel
   );

   // sequencer: one item at a time
   tcw_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_ready(rsp.ready), .sts, .cmd
   );

   // cell memory, cursors and result register
   tcw_dp #(.PAGES(PAGES), .PAGE_CELLS(PAGE_CELLS), .COLUMNS(COLUMNS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_func(req.func), .req_ch(req.ch), .req_col(req.col),
      .req_row(req.row), .req_attr(req.attr),
      .win_left, .win_top, .win_right, .win_bottom, .text_attr, .page_sel,
      .rsp_cursor_col(rsp.cursor_col), .rsp_cursor_row(rsp.cursor_row),
      .rsp_cursor_address(rsp.cursor_address), .rsp_cell_char(rsp.cell_char),
      .rsp_cell_attr(rsp.cell_attr), .rsp_scrolled(rsp.scrolled),
      .rsp_valid(rsp.valid)
   );

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready) else $error("accept while busy");
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(!req.ready)) else $error("result without item");
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready) else $error("pready low");
`endif

endmodule
